FILE: rtl/vms_pkg.sv
// Package for the vehicle mode supervisor: event and mode codes, fault bit
// positions and the structs passed between the pipeline stages.
// No dependencies.
`default_nettype none

package vms_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned FAULT_W = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 72;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT     = 3'd0,
    FUNC_COMMAND  = 3'd1,
    FUNC_TIMEOUT  = 3'd2,
    FUNC_FATAL    = 3'd3,
    FUNC_SAFETY   = 3'd4,
    FUNC_STATUS   = 3'd5
  } func_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT     = 3'd0,
    MODE_STANDBY  = 3'd1,
    MODE_DRIVE    = 3'd2,
    MODE_SAFESTOP = 3'd3,
    MODE_FAULT    = 3'd4
  } mode_t;

  localparam int unsigned FB_TIMEOUT = 0;
  localparam int unsigned FB_SAFETY  = 1;
  localparam int unsigned FB_FATAL   = 2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              event_flag;
    logic [TIME_W-1:0] now_ms;
  } event_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FAULT_W-1:0] fault_bits;
    logic [COUNT_W-1:0] change_count;
    logic [TIME_W-1:0]  last_change_ms;
    logic               drive_allowed;
  } snap_t;

endpackage

`default_nettype wire

FILE: rtl/vms_in_reg.sv
// Input register of the vehicle mode supervisor: captures one event
// transaction and holds it until the core takes it. Uses vms_pkg.
`default_nettype none

module vms_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire vms_pkg::event_t evt_in,
  input  wire logic           advance,
  output logic                valid,
  output vms_pkg::event_t     evt
);
  import vms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evt <= evt_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vms_core.sv
// Mode and fault state of the vehicle mode supervisor with the priority
// rules that pick the next mode for each event. Uses vms_pkg.
`default_nettype none

module vms_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire vms_pkg::event_t evt,
  output vms_pkg::snap_t       snap_next
);
  import vms_pkg::*;

  logic [MODE_W-1:0]  mode;
  logic [FAULT_W-1:0] fault;
  logic [COUNT_W-1:0] count;
  logic [TIME_W-1:0]  stamp;

  logic [MODE_W-1:0]  base_mode;
  logic [COUNT_W-1:0] base_count;
  logic [TIME_W-1:0]  base_stamp;
  logic [FAULT_W-1:0] fault_next;
  logic [MODE_W-1:0]  target;
  logic               do_move;
  logic [MODE_W-1:0]  mode_next;
  logic [COUNT_W-1:0] count_next;
  logic [TIME_W-1:0]  stamp_next;

  always_comb begin
    base_mode  = mode;
    base_count = count;
    base_stamp = stamp;
    fault_next = fault;
    target     = mode;
    do_move    = 1'b0;
    unique case (evt.func)
      FUNC_INIT: begin
        base_mode  = MODE_INIT;
        base_count = '0;
        base_stamp = evt.now_ms;
        fault_next = '0;
        target     = MODE_STANDBY;
        do_move    = 1'b1;
      end
      FUNC_COMMAND: begin
        fault_next[FB_TIMEOUT] = 1'b0;
        do_move = 1'b1;
        if (fault[FB_FATAL]) begin
          target = MODE_FAULT;
        end else if (fault[FB_SAFETY]) begin
          target = MODE_SAFESTOP;
        end else if (evt.event_flag) begin
          target = MODE_DRIVE;
        end else begin
          target = MODE_STANDBY;
        end
      end
      FUNC_TIMEOUT: begin
        fault_next[FB_TIMEOUT] = 1'b1;
        do_move = 1'b1;
        target  = fault[FB_FATAL] ? MODE_FAULT : MODE_SAFESTOP;
      end
      FUNC_FATAL: begin
        if (evt.event_flag) begin
          fault_next[FB_FATAL] = 1'b1;
          do_move = 1'b1;
          target  = MODE_FAULT;
        end else if (fault[FB_FATAL]) begin
          fault_next[FB_FATAL] = 1'b0;
          do_move = 1'b1;
          target  = (fault[FB_TIMEOUT] || fault[FB_SAFETY]) ? MODE_SAFESTOP
                                                            : MODE_STANDBY;
        end
      end
      FUNC_SAFETY: begin
        if (evt.event_flag) begin
          fault_next[FB_SAFETY] = 1'b1;
          do_move = 1'b1;
          target  = fault[FB_FATAL] ? MODE_FAULT : MODE_SAFESTOP;
        end else if (fault[FB_SAFETY]) begin
          fault_next[FB_SAFETY] = 1'b0;
          do_move = 1'b1;
          if (fault[FB_FATAL]) begin
            target = MODE_FAULT;
          end else if (fault[FB_TIMEOUT]) begin
            target = MODE_SAFESTOP;
          end else begin
            target = MODE_STANDBY;
          end
        end
      end
      default: begin
        do_move = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next  = base_mode;
    count_next = base_count;
    stamp_next = base_stamp;
    if (do_move && (target != base_mode)) begin
      mode_next  = target;
      count_next = base_count + COUNT_W'(1);
      stamp_next = evt.now_ms;
    end
  end

  always_comb begin
    snap_next.mode           = mode_next;
    snap_next.fault_bits     = fault_next;
    snap_next.change_count   = count_next;
    snap_next.last_change_ms = stamp_next;
    snap_next.drive_allowed  = (mode_next == MODE_DRIVE) && (fault_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_INIT;
      fault <= '0;
      count <= '0;
      stamp <= '0;
    end else if (advance) begin
      mode  <= mode_next;
      fault <= fault_next;
      count <= count_next;
      stamp <= stamp_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vms_out_reg.sv
// Result register of the vehicle mode supervisor: holds one snapshot
// transaction until the downstream side takes it. Uses vms_pkg.
`default_nettype none

module vms_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire vms_pkg::snap_t snap_in,
  input  wire logic           take,
  output logic                valid,
  output vms_pkg::snap_t      snap
);
  import vms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= snap_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vehicle_mode_supervisor.sv
// Top level of the vehicle mode supervisor: input register, mode core and
// result register. Depends on vms_pkg, vms_in_reg, vms_core, vms_out_reg.
`default_nettype none

// Each event transaction on the s_ side returns exactly one snapshot
// transaction on the m_ side: mode, fault bits, change count, time of the
// last mode change and drive_allowed, all as they stand after the event.
// An event is held in the input register until the result register is free or
// being taken, then moves into the result register, where its result is offered
// on the m_ side until taken; the block takes one event per clock
// as long as the m_ side keeps up, the state registers of the core being the
// only loop. Reset puts the block in init mode with no faults, a zero count
// and a zero timestamp.

module vehicle_mode_supervisor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // event_flag, now_ms[31:0], zero pad
  input  wire logic [2:0]  s_tuser,  // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // mode, fault_bits, change_count,
                                     // last_change_ms, drive_allowed, pad
);
  import vms_pkg::*;

  event_t evt_in;
  event_t evt;
  snap_t  snap_next;
  snap_t  snap;
  logic   in_valid;
  logic   s_load;
  logic   advance;

  assign evt_in.func       = s_tuser;
  assign evt_in.event_flag = s_tdata[0];
  assign evt_in.now_ms     = s_tdata[TIME_W:1];

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_load   = s_tvalid && s_tready;

  vms_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (s_load),
    .evt_in  (evt_in),
    .advance (advance),
    .valid   (in_valid),
    .evt     (evt)
  );

  vms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .evt       (evt),
    .snap_next (snap_next)
  );

  vms_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .snap_in (snap_next),
    .take    (m_tready),
    .valid   (m_tvalid),
    .snap    (snap)
  );

  assign m_tdata = {1'b0, snap.drive_allowed, snap.last_change_ms,
                    snap.change_count, snap.fault_bits, snap.mode};

endmodule

`default_nettype wire
